// ===== design/tse_pkg.sv =====
// Shared types and constants for the Taylor-series sine evaluator.
// Used by tse_mul, tse_cell and taylor_sine_evaluator; depends on nothing.
`timescale 1ns / 1ps

package tse_pkg;

	// Pi and two pi in Q60, truncated.
	localparam logic [63:0] PI_Q60     = 64'h3243_F6A8_885A_308D;
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;

	// Output format: rounding and saturation in Q30.
	localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0200_0000;
	localparam logic [63:0] ONE_Q30    = 64'h0000_0000_4000_0000;
	localparam int          OUT_SHIFT  = 26;

	// Context that travels with one angle through the term chain.
	typedef struct packed {
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        x2;
		logic               neg;
		logic [3:0]         n;
	} ctx_t;

endpackage

// ===== design/tse_mul.sv =====
// Pipelined 64x64 unsigned multiplier, one 32x32 partial product per stage.
// Carries a tse_pkg::ctx_t context alongside the operands.
`timescale 1ns / 1ps

module tse_mul #(
	parameter int SHIFT = 56
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	input  tse_pkg::ctx_t side_in,
	output logic          v_out,
	output logic [63:0]   p,
	output tse_pkg::ctx_t side_out
);

	logic [63:0]   a_s    [4];
	logic [63:0]   b_s    [4];
	logic [127:0]  acc_s  [4];
	tse_pkg::ctx_t side_s [4];
	logic          v_s    [4];

	genvar k;
	generate
		for (k = 0; k < 4; k++) begin : g_stage
			localparam int AI = k >> 1;
			localparam int BI = k & 1;
			logic [63:0]   a_prev;
			logic [63:0]   b_prev;
			logic [127:0]  acc_prev;
			tse_pkg::ctx_t side_prev;
			logic          v_prev;
			logic [63:0]   pp;

			if (k == 0) begin : g_first
				assign a_prev    = a;
				assign b_prev    = b;
				assign acc_prev  = '0;
				assign side_prev = side_in;
				assign v_prev    = v_in;
			end else begin : g_next
				assign a_prev    = a_s[k-1];
				assign b_prev    = b_s[k-1];
				assign acc_prev  = acc_s[k-1];
				assign side_prev = side_s[k-1];
				assign v_prev    = v_s[k-1];
			end

			// One partial product, aligned and added into the running sum.
			assign pp = a_prev[32*AI +: 32] * b_prev[32*BI +: 32];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= v_prev;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					a_s[k]    <= a_prev;
					b_s[k]    <= b_prev;
					acc_s[k]  <= acc_prev + ({64'b0, pp} << (32 * (AI + BI)));
					side_s[k] <= side_prev;
				end
			end
		end
	endgenerate

	assign v_out    = v_s[3];
	assign p        = acc_s[3][SHIFT +: 64];
	assign side_out = side_s[3];

endmodule

// ===== design/tse_cell.sv =====
// One Taylor term cell: adds its term into the sum and forms the next term.
// Depends on tse_pkg and tse_mul.
`timescale 1ns / 1ps

module tse_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  tse_pkg::ctx_t c_in,
	output logic          v_out,
	output tse_pkg::ctx_t c_out
);

	localparam int          D     = (2 * IDX + 2) * (2 * IDX + 3);
	localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / 64'(D);
	localparam bit          SUB   = (IDX % 2) == 1;

	tse_pkg::ctx_t upd;
	tse_pkg::ctx_t m1_side;
	tse_pkg::ctx_t m2_side;
	logic [63:0]   p1;
	logic [63:0]   p2;
	logic          m1_v;

	// Terms alternate in sign; only the first n terms are summed.
	always_comb begin
		upd = c_in;
		if (4'(IDX) < c_in.n) begin
			if (SUB) begin
				upd.sum = c_in.sum - $signed(c_in.term);
			end else begin
				upd.sum = c_in.sum + $signed(c_in.term);
			end
		end
	end

	// Next term: (term * x^2) in Q56, then times the reciprocal of d.
	tse_mul #(.SHIFT(56)) u_mul_x2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_in),
		.a        (upd.term),
		.b        (upd.x2),
		.side_in  (upd),
		.v_out    (m1_v),
		.p        (p1),
		.side_out (m1_side)
	);

	tse_mul #(.SHIFT(64)) u_mul_rcp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (m1_v),
		.a        (p1),
		.b        (RECIP),
		.side_in  (m1_side),
		.v_out    (v_out),
		.p        (p2),
		.side_out (m2_side)
	);

	always_comb begin
		c_out      = m2_side;
		c_out.term = p2;
	end

endmodule

// ===== design/taylor_sine_evaluator.sv =====
// Top level of the Taylor-series sine evaluator: reduction, term chain, output.
// Depends on tse_pkg, tse_mul and tse_cell.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_ready, angle_in     | in
//   output  | out_valid, out_ready, sine_out   | out
//   config  | cfg_valid, cfg_ready, term_count | in
//
// One angle is accepted per cycle while the skid register is empty. From acceptance, an
// angle passes through the range reduction steps, the squarer and the two four-stage
// multipliers in each term cell on its way to the result register.
// Reset clears all valid flags and sets term_count to ten; no clearing pass is needed.
// A stalled output moves one result into a skid register; the pipeline halts only
// while that register is full. Configuration writes are always accepted.
`timescale 1ns / 1ps

module taylor_sine_evaluator #(
	parameter int MAX_TERMS       = 10,
	parameter int ANGLE_FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] angle_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sine_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  term_count
);

	localparam int              SHIFT     = 28 - ANGLE_FRAC_BITS;
	localparam int              RED_STEPS = 29 - ANGLE_FRAC_BITS;
	localparam int              RW        = 65;
	localparam logic [63:0]     MODULUS   = tse_pkg::TWO_PI_Q60 >> SHIFT;
	localparam logic [RW-1:0]   MOD_TOP   = {1'b0, MODULUS} << RED_STEPS;

	logic          en;
	logic [3:0]    term_count_q;
	logic [3:0]    n_clamp;
	logic [RW-1:0] scaled;
	logic [RW-1:0] r0;

	logic [RW-1:0] red_r_s [RED_STEPS+1];
	logic [3:0]    red_n_s [RED_STEPS+1];
	logic          red_v_s [RED_STEPS+1];

	logic [63:0]   rem;
	logic [63:0]   x60;
	logic [63:0]   x60_ref;
	logic          is_hi;
	logic [63:0]   refl_x56_s;
	logic          refl_neg_s;
	logic [3:0]    refl_n_s;
	logic          refl_v_s;

	tse_pkg::ctx_t sq_side_in;
	tse_pkg::ctx_t sq_side_out;
	logic [63:0]   sq_p;
	logic          sq_v;

	tse_pkg::ctx_t c_ctx [MAX_TERMS+1];
	logic          c_v   [MAX_TERMS+1];

	logic [63:0]   fin_mag_s1;
	logic          fin_neg_s1;
	logic          fin_v_s1;
	logic [63:0]   q_full;
	logic [63:0]   q_sat;
	logic [31:0]   res_s2;
	logic          res_v_s2;

	logic          take;
	logic          out_v_q;
	logic [31:0]   out_q;
	logic          skid_v_q;
	logic [31:0]   skid_q;

	// The whole pipeline moves unless the skid register holds a result.
	assign en        = !skid_v_q;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// Term count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= 4'd10;
		end else if (cfg_valid) begin
			term_count_q <= term_count;
		end
	end

	// Clamp the term count into one to MAX_TERMS.
	always_comb begin
		if (term_count_q == 4'd0) begin
			n_clamp = 4'd1;
		end else if (term_count_q > 4'(MAX_TERMS)) begin
			n_clamp = 4'(MAX_TERMS);
		end else begin
			n_clamp = term_count_q;
		end
	end

	// Scale the angle by 2^32; a negative angle is lifted by a multiple of the modulus.
	assign scaled = {angle_in[31], angle_in, 32'b0};
	assign r0     = angle_in[31] ? scaled + MOD_TOP : scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_v_s[0] <= 1'b0;
		end else if (en) begin
			red_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_r_s[0] <= r0;
			red_n_s[0] <= n_clamp;
		end
	end

	// Restoring reduction, one shifted modulus per stage.
	genvar k;
	generate
		for (k = 0; k < RED_STEPS; k++) begin : g_red
			localparam logic [RW-1:0] SUB = {1'b0, MODULUS} << (RED_STEPS - 1 - k);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					red_v_s[k+1] <= 1'b0;
				end else if (en) begin
					red_v_s[k+1] <= red_v_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					red_r_s[k+1] <= (red_r_s[k] >= SUB) ? red_r_s[k] - SUB : red_r_s[k];
					red_n_s[k+1] <= red_n_s[k];
				end
			end
		end
	endgenerate

	// Back to Q60 and reflect the upper half turn.
	assign rem     = red_r_s[RED_STEPS][63:0];
	assign x60     = rem << SHIFT;
	assign is_hi   = x60 >= tse_pkg::PI_Q60;
	assign x60_ref = is_hi ? tse_pkg::TWO_PI_Q60 - x60 : x60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refl_v_s <= 1'b0;
		end else if (en) begin
			refl_v_s <= red_v_s[RED_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			refl_x56_s <= x60_ref >> 4;
			refl_neg_s <= is_hi;
			refl_n_s   <= red_n_s[RED_STEPS];
		end
	end

	// Square of the reduced angle in Q56.
	always_comb begin
		sq_side_in      = '0;
		sq_side_in.term = refl_x56_s;
		sq_side_in.neg  = refl_neg_s;
		sq_side_in.n    = refl_n_s;
	end

	tse_mul #(.SHIFT(56)) u_sq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (refl_v_s),
		.a        (refl_x56_s),
		.b        (refl_x56_s),
		.side_in  (sq_side_in),
		.v_out    (sq_v),
		.p        (sq_p),
		.side_out (sq_side_out)
	);

	always_comb begin
		c_ctx[0]    = sq_side_out;
		c_ctx[0].x2 = sq_p;
	end
	assign c_v[0] = sq_v;

	// Chain of term cells.
	genvar i;
	generate
		for (i = 0; i < MAX_TERMS; i++) begin : g_cell
			tse_cell #(.IDX(i)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.v_in   (c_v[i]),
				.c_in   (c_ctx[i]),
				.v_out  (c_v[i+1]),
				.c_out  (c_ctx[i+1])
			);
		end
	endgenerate

	// Sign and magnitude of the sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
			res_v_s2 <= 1'b0;
		end else if (en) begin
			fin_v_s1 <= c_v[MAX_TERMS];
			res_v_s2 <= fin_v_s1;
		end
	end

	// Round to Q30, saturate to one and apply the sign.
	assign q_full = (fin_mag_s1 + tse_pkg::ROUND_HALF) >> tse_pkg::OUT_SHIFT;
	assign q_sat  = (q_full > tse_pkg::ONE_Q30) ? tse_pkg::ONE_Q30 : q_full;

	always_ff @(posedge clk) begin
		if (en) begin
			if (c_ctx[MAX_TERMS].sum < 0) begin
				fin_mag_s1 <= 64'(-c_ctx[MAX_TERMS].sum);
				fin_neg_s1 <= !c_ctx[MAX_TERMS].neg;
			end else begin
				fin_mag_s1 <= 64'(c_ctx[MAX_TERMS].sum);
				fin_neg_s1 <= c_ctx[MAX_TERMS].neg;
			end
			res_s2 <= fin_neg_s1 ? 32'(-q_sat[31:0]) : q_sat[31:0];
		end
	end

	// Output register with a skid register behind it.
	assign take = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (res_v_s2) begin
			if (take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (res_v_s2) begin
			if (take) begin
				out_q <= res_s2;
			end else begin
				skid_q <= res_s2;
			end
		end
	end

	assign out_valid = out_v_q;
	assign sine_out  = out_q;

	// The skid register fills only behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	// A parked result stays put until the output drains.
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_ready |=> skid_v_q && $stable(skid_q))
		else $error("skid register lost its result during a stall");

	// Results never leave the range of plus or minus one.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(sine_out) <= 32'sd1073741824)
			&& ($signed(sine_out) >= -32'sd1073741824))
		else $error("sine result outside plus or minus one");

endmodule

// ===== dv/testbench.sv =====
// Testbench for taylor_sine_evaluator: random and directed angles across term counts.
// Depends on tse_pkg for the pi constants and on the block itself.
`timescale 1ns / 1ps

// Predicts each sine and checks results in order of acceptance.
class sine_scoreboard;
	localparam int FRAC_SHIFT = 28 - 24;
	logic [3:0]  terms;
	logic [31:0] pending[$];
	int          errors;
	int          checked;

	function new();
		terms   = 4'd10;
		errors  = 0;
		checked = 0;
	endfunction

	// Full 128-bit product of two unsigned values, shifted right and truncated.
	function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	function logic [31:0] sine_of(logic [31:0] ang);
		longint      scaled, modulus, rem, sum;
		logic [63:0] x60, x56, x2, term, mag, q, d;
		bit          neg;
		int          n;
		scaled  = longint'($signed(ang)) * 64'sd4294967296;
		modulus = longint'(tse_pkg::TWO_PI_Q60 >> FRAC_SHIFT);
		rem     = scaled % modulus;
		if (rem < 0)
			rem += modulus;
		x60 = 64'(rem) << FRAC_SHIFT;
		neg = 0;
		// Angles in the upper half turn are reflected and negated.
		if (x60 >= tse_pkg::PI_Q60) begin
			x60 = tse_pkg::TWO_PI_Q60 - x60;
			neg = 1;
		end
		n = terms;
		if (n < 1)
			n = 1;
		if (n > 10)
			n = 10;
		x56  = x60 >> 4;
		x2   = mul_shift(x56, x56, 56);
		term = x56;
		sum  = 0;
		// Alternating series with constant reciprocals of the term divisors.
		for (int i = 0; i < n; i++) begin
			if (i & 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
			if (i + 1 < n) begin
				d    = 64'((2 * i + 2) * (2 * i + 3));
				term = mul_shift(mul_shift(term, x2, 56), 64'hFFFF_FFFF_FFFF_FFFF / d, 64);
			end
		end
		if (sum < 0) begin
			neg = !neg;
			mag = 64'(-sum);
		end else begin
			mag = 64'(sum);
		end
		q = (mag + tse_pkg::ROUND_HALF) >> tse_pkg::OUT_SHIFT;
		if (q > tse_pkg::ONE_Q30)
			q = tse_pkg::ONE_Q30;
		return neg ? 32'(-q) : q[31:0];
	endfunction

	function void note_angle(logic [31:0] ang);
		pending.push_back(sine_of(ang));
	endfunction

	function void check_sine(logic [31:0] actual);
		logic [31:0] exp_sine;
		if (pending.size() == 0) begin
			$error("sine_out 0x%08h arrived with no angle outstanding", actual);
			errors++;
			return;
		end
		exp_sine = pending.pop_front();
		checked++;
		if (actual !== exp_sine) begin
			$error("sine_out mismatch: expected %0d, actual %0d", $signed(exp_sine),
				$signed(actual));
			errors++;
		end
	endfunction
endclass

module testbench;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] angle_in;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] sine_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  term_count;

	localparam int LATENCY = 93;
	localparam logic [31:0] PI_Q24 = 32'h0324_3F6A;

	sine_scoreboard sb = new();
	int burst_left;
	int sent;

	taylor_sine_evaluator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .angle_in(angle_in),
		.out_valid(out_valid), .out_ready(out_ready), .sine_out(sine_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .term_count(term_count)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver stall pattern: stretches of full speed, then random stalls.
	int rx_cnt = 0;
	always @(negedge clk) begin
		rx_cnt <= rx_cnt + 1;
		if ((rx_cnt / 200) % 3 == 0)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0) && (rx_cnt % 37 > 4);
	end

	// Check every result transaction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_sine(sine_out);
	end

	// Present one angle; valid stays high across a burst.
	task automatic send_angle(input logic [31:0] ang);
		@(negedge clk);
		in_valid <= 1'b1;
		angle_in <= ang;
		do @(posedge clk); while (!in_ready);
		sb.note_angle(ang);
		sent++;
		if (--burst_left <= 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
		end
	endtask

	// Write term_count once the pipeline has drained.
	task automatic write_terms(input logic [3:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (sb.pending.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		@(negedge clk);
		cfg_valid  <= 1'b1;
		term_count <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.terms = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_angles(input int count);
		logic [31:0] a;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 3))
				0: a = $urandom();
				1: a = 32'($signed($urandom_range(0, 2 * PI_Q24)) - $signed(PI_Q24));
				2: a = $urandom_range(0, 32'h0400_0000) ^ {32{$urandom_range(0, 1) == 1}};
				default: a = PI_Q24 + $urandom_range(0, 8) - 4;
			endcase
			send_angle(a);
		end
	endtask

	logic [3:0] phase_terms[6] = '{4'd10, 4'd1, 4'd0, 4'd15, 4'd5, 4'd3};

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		angle_in   = '0;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		term_count = 4'd10;
		sent       = 0;
		burst_left = 8;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, pi boundaries, quarter turns.
		send_angle(32'h0000_0000);
		send_angle(32'h0000_0001);
		send_angle(32'hFFFF_FFFF);
		send_angle(32'h7FFF_FFFF);
		send_angle(32'h8000_0000);
		send_angle(PI_Q24);
		send_angle(PI_Q24 - 1);
		send_angle(PI_Q24 + 1);
		send_angle(-PI_Q24);
		send_angle(PI_Q24 >> 1);
		send_angle(-(PI_Q24 >> 1));
		send_angle(PI_Q24 << 1);
		send_angle((PI_Q24 << 1) - 1);
		send_angle(32'h5555_5555);
		send_angle(32'hAAAA_AAAA);
		random_angles(285);

		for (int p = 0; p < 6; p++) begin
			write_terms(p == 0 ? 4'd10 : phase_terms[p]);
			random_angles(p == 0 ? 20 : 260);
		end
		write_terms($urandom_range(2, 9));
		random_angles(250);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (sb.pending.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("Sent %0d angles over term counts 0, 1, 3, 5, 10, 15 and one random count;",
			sent);
		$display("%0d sines checked, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end
endmodule
